@@ src/assert_macros.svh @@
// Assertion macros for the extent file table.
// Bodies assume a clock named clk and a synchronous active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

@@ src/ffeft_pkg.sv @@
// Shared constants, codes and controller/datapath command and status types
// for the extent file table. No dependencies.
`timescale 1ns / 1ps

package ffeft_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ADDRESS_BITS  = 10;
  localparam int NAME_BITS     = 64;
  localparam int ACTION_BITS   = 2;
  localparam int STATUS_BITS   = 3;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int PREV_W = ADDRESS_BITS + 1;
  localparam int SUM_W  = ADDRESS_BITS + 2;

  localparam logic [ADDRESS_BITS-1:0] SPACE_END_RESET = ADDRESS_BITS'(999);

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_STORE = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_ERASE = 2'd2
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_BADNAME  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_CNT
  } idx_op_t;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_BELOW,
    RD_ABOVE
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_CODE,
    RES_ENTRY,
    RES_NEW
  } res_kind_t;

  typedef struct packed {
    logic      load_item;
    idx_op_t   idx_op;
    rd_sel_t   rd_sel;
    logic      prev_clr;
    logic      prev_adv;
    logic      pos_ld;
    logic      wr_shift;
    logic      wr_new;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_ld;
    res_kind_t res_kind;
    status_t   res_status;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                   name_zero;
    logic [ACTION_BITS-1:0] action;
    logic                   full;
    logic                   idx_lt_cnt;
    logic                   name_hit;
    logic                   gap_fit;
    logic                   end_fit;
    logic                   idx_eq_pos;
    logic                   dn_more;
    logic [CNT_W-1:0]       count;
  } dp_sts_t;

endpackage

@@ src/ffeft_if.sv @@
// Valid/ready channel interfaces for the extent file table: request and result.
// Depends on ffeft_pkg for field widths.
`timescale 1ns / 1ps

interface ffeft_in_if import ffeft_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACTION_BITS-1:0]  action;
  logic [NAME_BITS-1:0]    file_name;
  logic [ADDRESS_BITS-1:0] file_length;

  modport source (output valid, action, file_name, file_length, input ready);
  modport sink   (input valid, action, file_name, file_length, output ready);
endinterface

interface ffeft_out_if import ffeft_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_BITS-1:0]  status;
  logic [ADDRESS_BITS-1:0] start_address;
  logic [ADDRESS_BITS-1:0] extent_length;

  modport source (output valid, status, start_address, extent_length, input ready);
  modport sink   (input valid, status, start_address, extent_length, output ready);
endinterface

@@ src/ffeft_dp.sv @@
// Datapath of the extent file table: entry storage, walk pointer, gap tracking,
// result and output registers. Depends on ffeft_pkg.
`timescale 1ns / 1ps

module ffeft_dp import ffeft_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_sts_t                 sts,
  input  logic [ACTION_BITS-1:0]  in_action,
  input  logic [NAME_BITS-1:0]    in_file_name,
  input  logic [ADDRESS_BITS-1:0] in_file_length,
  input  logic                    cfg_we,
  input  logic [ADDRESS_BITS-1:0] cfg_wdata,
  output logic [STATUS_BITS-1:0]  out_status,
  output logic [ADDRESS_BITS-1:0] out_start_address,
  output logic [ADDRESS_BITS-1:0] out_extent_length
);

  logic [NAME_BITS-1:0]    ent_name_r  [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0] ent_start_r [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0] ent_len_r   [TABLE_ENTRIES];

  logic [ADDRESS_BITS-1:0] space_end_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        pos_r;
  logic [PREV_W-1:0]       prev_r;

  logic [ACTION_BITS-1:0]  item_action_r;
  logic [NAME_BITS-1:0]    item_name_r;
  logic [ADDRESS_BITS-1:0] item_len_r;

  status_t                 res_status_r;
  logic [ADDRESS_BITS-1:0] res_start_r, res_len_r;
  logic [STATUS_BITS-1:0]  out_status_r;
  logic [ADDRESS_BITS-1:0] out_start_r, out_len_r;

  logic [CNT_W-1:0]        rd_ptr;
  logic [NAME_BITS-1:0]    rd_name;
  logic [ADDRESS_BITS-1:0] rd_start, rd_len;
  logic [SUM_W-1:0]        fit_need;
  logic [IDX_W-1:0]        wr_ptr;

  always_comb begin
    case (cmd.rd_sel)
      RD_BELOW: rd_ptr = idx_r - CNT_W'(1);
      RD_ABOVE: rd_ptr = idx_r + CNT_W'(1);
      default:  rd_ptr = idx_r;
    endcase
  end

  assign rd_name  = ent_name_r[rd_ptr[IDX_W-1:0]];
  assign rd_start = ent_start_r[rd_ptr[IDX_W-1:0]];
  assign rd_len   = ent_len_r[rd_ptr[IDX_W-1:0]];
  assign wr_ptr   = idx_r[IDX_W-1:0];

  // end of the new extent if it started at the current gap
  assign fit_need = SUM_W'(prev_r) + SUM_W'(item_len_r);

  always_comb begin
    sts.name_zero  = (item_name_r == '0);
    sts.action     = item_action_r;
    sts.full       = (count_r >= CNT_W'(TABLE_ENTRIES));
    sts.idx_lt_cnt = (idx_r < count_r);
    sts.name_hit   = (rd_name == item_name_r);
    sts.gap_fit    = (SUM_W'(rd_start) >= fit_need);
    sts.end_fit    = (SUM_W'(space_end_r) >= fit_need);
    sts.idx_eq_pos = (idx_r == pos_r);
    sts.dn_more    = (CNT_W'(idx_r + CNT_W'(1)) < count_r);
    sts.count      = count_r;
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_CLR: idx_nxt = '0;
      IDX_INC: idx_nxt = idx_r + CNT_W'(1);
      IDX_DEC: idx_nxt = idx_r - CNT_W'(1);
      IDX_CNT: idx_nxt = count_r;
      default: idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_end_r <= SPACE_END_RESET;
      count_r     <= '0;
      idx_r       <= '0;
    end else begin
      if (cfg_we) begin
        space_end_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_action_r <= in_action;
      item_name_r   <= in_file_name;
      item_len_r    <= in_file_length;
    end
    if (cmd.prev_clr) begin
      prev_r <= '0;
    end else if (cmd.prev_adv) begin
      prev_r <= PREV_W'(rd_start) + PREV_W'(rd_len);
    end
    if (cmd.pos_ld) begin
      pos_r <= idx_r;
    end
    if (cmd.wr_new) begin
      ent_name_r[wr_ptr]  <= item_name_r;
      ent_start_r[wr_ptr] <= prev_r[ADDRESS_BITS-1:0];
      ent_len_r[wr_ptr]   <= item_len_r;
    end else if (cmd.wr_shift) begin
      ent_name_r[wr_ptr]  <= rd_name;
      ent_start_r[wr_ptr] <= rd_start;
      ent_len_r[wr_ptr]   <= rd_len;
    end
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_kind)
        RES_ENTRY: begin
          res_start_r <= rd_start;
          res_len_r   <= rd_len;
        end
        RES_NEW: begin
          res_start_r <= prev_r[ADDRESS_BITS-1:0];
          res_len_r   <= item_len_r;
        end
        default: begin
          res_start_r <= '0;
          res_len_r   <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
      out_len_r    <= res_len_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_start_address = out_start_r;
  assign out_extent_length = out_len_r;

endmodule

@@ src/ffeft_ctrl.sv @@
// Controller of the extent file table: sequences check, lookup, gap search and
// table shifts, and owns the handshakes. Depends on ffeft_pkg.
`timescale 1ns / 1ps

module ffeft_ctrl import ffeft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOK,
    S_GAP,
    S_UP,
    S_DN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd            = '0;
    cmd.idx_op     = IDX_HOLD;
    cmd.rd_sel     = RD_CUR;
    cmd.res_kind   = RES_CODE;
    cmd.res_status = ST_OK;
    state_nxt      = state_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end

      S_CHECK: begin
        cmd.idx_op = IDX_CLR;
        state_nxt  = S_LOOK;
        if (sts.name_zero) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_BADNAME;
          state_nxt      = S_FIN;
        end else if (sts.action == ACT_STORE) begin
          if (sts.full) begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_FULL;
            state_nxt      = S_FIN;
          end
        end else if (sts.action != ACT_FIND && sts.action != ACT_ERASE) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end
      end

      S_LOOK: begin
        if (sts.idx_lt_cnt) begin
          if (sts.name_hit) begin
            case (sts.action)
              ACT_STORE: begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = ST_EXISTS;
                state_nxt      = S_FIN;
              end
              ACT_FIND: begin
                cmd.res_ld     = 1'b1;
                cmd.res_kind   = RES_ENTRY;
                cmd.res_status = ST_OK;
                state_nxt      = S_FIN;
              end
              default: begin
                state_nxt = S_DN;
              end
            endcase
          end else begin
            cmd.idx_op = IDX_INC;
          end
        end else if (sts.action == ACT_STORE) begin
          cmd.idx_op   = IDX_CLR;
          cmd.prev_clr = 1'b1;
          state_nxt    = S_GAP;
        end else begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end
      end

      S_GAP: begin
        if (sts.idx_lt_cnt && !sts.gap_fit) begin
          cmd.prev_adv = 1'b1;
          cmd.idx_op   = IDX_INC;
        end else if (sts.idx_lt_cnt || sts.end_fit) begin
          cmd.pos_ld = 1'b1;
          cmd.idx_op = IDX_CNT;
          state_nxt  = S_UP;
        end else begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_NOSPACE;
          state_nxt      = S_FIN;
        end
      end

      S_UP: begin
        if (sts.idx_eq_pos) begin
          cmd.wr_new     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.res_ld     = 1'b1;
          cmd.res_kind   = RES_NEW;
          cmd.res_status = ST_OK;
          state_nxt      = S_FIN;
        end else begin
          cmd.rd_sel   = RD_BELOW;
          cmd.wr_shift = 1'b1;
          cmd.idx_op   = IDX_DEC;
        end
      end

      S_DN: begin
        if (sts.dn_more) begin
          cmd.rd_sel   = RD_ABOVE;
          cmd.wr_shift = 1'b1;
          cmd.idx_op   = IDX_INC;
        end else begin
          cmd.cnt_dec    = 1'b1;
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/first_fit_extent_file_table.sv @@
// First-fit extent file table, top level: joins controller and datapath.
// Depends on ffeft_pkg, ffeft_if, ffeft_ctrl, ffeft_dp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   in_ch carries one request item (action, file_name, file_length), taken when
//   valid and ready are both high. out_ch returns exactly one result item
//   (status, start_address, extent_length) per request, in request order.
//   cfg_we/cfg_wdata write space_end; write it only while no request is open.
// Timing
//   One request is worked at a time; a single walk pointer over the entry
//   table sets the cost, one entry per cycle. Each request passes a check
//   step, then a lookup walk over the held entries for its name; erase then
//   shifts the entries above the hit down, and store follows with a gap
//   search and an upward shift to insert. A rejected name or a full-table
//   store answers straight from the check step. Every result then goes
//   through the output register.
// Reset
//   rst_n (synchronous, low) empties the table, sets space_end to 999 and
//   drops any pending result. No clearing pass is needed.
// Stall
//   The result sits in an output register; a new request is accepted while
//   it waits, and is held at its final step until the register frees up.

module first_fit_extent_file_table import ffeft_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  ffeft_in_if.sink                in_ch,
  ffeft_out_if.source             out_ch,
  input  logic                    cfg_we,
  input  logic [ADDRESS_BITS-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;
  logic      out_valid;

  // sequence the walk over the table
  ffeft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold entries, compare names, measure gaps, shift rows
  ffeft_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_ch.action),
    .in_file_name      (in_ch.file_name),
    .in_file_length    (in_ch.file_length),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_status        (out_ch.status),
    .out_start_address (out_ch.start_address),
    .out_extent_length (out_ch.extent_length)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // the file count never passes the table size
  `ASSERT_NEVER(a_count_range, sts.count > CNT_W'(TABLE_ENTRIES))
  // never insert into a full table
  `ASSERT_NEVER(a_no_insert_full, cmd.wr_new && sts.full)
  // never overwrite a result the receiver has not taken
  `ASSERT_NEVER(a_no_out_overwrite, cmd.out_load && out_ch.valid && !out_ch.ready)
  // an accepted request closes the input until its work is done
  `ASSERT_ALWAYS(a_one_in_flight, (in_ch.valid && in_ch.ready) |=> !in_ch.ready)

endmodule

@@ sim/tb_first_fit_extent_file_table.sv @@
// Testbench for first_fit_extent_file_table: random and directed store, find and erase
// items against a cycle-free model of the extent table. Depends on ffeft_pkg, ffeft_if
// and the block itself.
`timescale 1ns / 1ps

module tb_first_fit_extent_file_table;
  import ffeft_pkg::*;

  // Action code 3 is outside the enum; the block must answer it as not found.
  localparam logic [ACTION_BITS-1:0] ACT_UNDEFINED = 2'd3;
  localparam int NAME_POOL = 24;
  localparam int PHASE_ITEMS = 190;

  typedef struct {
    logic [ACTION_BITS-1:0]  action;
    logic [NAME_BITS-1:0]    name;
    logic [ADDRESS_BITS-1:0] len;
  } request_t;

  typedef struct {
    status_t                 status;
    logic [ADDRESS_BITS-1:0] start;
    logic [ADDRESS_BITS-1:0] len;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ADDRESS_BITS-1:0] cfg_wdata = '0;

  ffeft_in_if  req_ch ();
  ffeft_out_if res_ch ();

  first_fit_extent_file_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Model of the extent table: valid entries sit in slots 0 .. file_cnt-1,
  // sorted by start address.
  logic [NAME_BITS-1:0]    ext_name [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0] ext_start [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0] ext_len [TABLE_ENTRIES];
  int                      file_cnt = 0;
  logic [ADDRESS_BITS-1:0] space_limit = SPACE_END_RESET;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  logic [NAME_BITS-1:0] name_pool [NAME_POOL];

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int mismatches = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit steady_traffic = 1'b0;
  request_t drive_req;
  request_t seen_req;
  result_t  due_result;

  // Drive every channel input to a known value before the first edge.
  initial begin
    req_ch.valid = 1'b0;
    req_ch.action = ACT_STORE;
    req_ch.file_name = '0;
    req_ch.file_length = '0;
    res_ch.ready = 1'b0;
  end

  function automatic int slot_of(logic [NAME_BITS-1:0] name);
    int i;
    for (i = 0; i < file_cnt; i++)
      if (ext_name[i] == name) return i;
    return -1;
  endfunction

  // Work out the answer to one item and apply its effect on the table.
  function automatic result_t predict_request(request_t r);
    result_t res;
    int hit, prev, slot, i;
    bit placed;
    res.status = ST_OK;
    res.start = '0;
    res.len = '0;
    hit = slot_of(r.name);
    if (r.name == '0) begin
      res.status = ST_BADNAME;
    end else begin
      case (r.action)
        ACT_STORE: begin
          if (file_cnt >= TABLE_ENTRIES) begin
            res.status = ST_FULL;
          end else if (hit >= 0) begin
            res.status = ST_EXISTS;
          end else begin
            // First fit: walk the gaps in address order, then the tail gap.
            prev = 0;
            placed = 1'b0;
            slot = file_cnt;
            for (i = 0; i < file_cnt && !placed; i++) begin
              if (int'(ext_start[i]) - prev >= int'(r.len)) begin
                placed = 1'b1;
                slot = i;
              end else begin
                prev = int'(ext_start[i]) + int'(ext_len[i]);
              end
            end
            // A tail gap below zero never fits.
            if (!placed && int'(space_limit) - prev >= int'(r.len)) begin
              placed = 1'b1;
              slot = file_cnt;
            end
            if (!placed) begin
              res.status = ST_NOSPACE;
            end else begin
              for (i = file_cnt; i > slot; i--) begin
                ext_name[i] = ext_name[i-1];
                ext_start[i] = ext_start[i-1];
                ext_len[i] = ext_len[i-1];
              end
              ext_name[slot] = r.name;
              ext_start[slot] = prev[ADDRESS_BITS-1:0];
              ext_len[slot] = r.len;
              file_cnt++;
              res.start = prev[ADDRESS_BITS-1:0];
              res.len = r.len;
            end
          end
        end
        ACT_FIND: begin
          if (hit < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.start = ext_start[hit];
            res.len = ext_len[hit];
          end
        end
        ACT_ERASE: begin
          if (hit < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            // Close up the table behind the removed entry.
            for (i = hit; i + 1 < file_cnt; i++) begin
              ext_name[i] = ext_name[i+1];
              ext_start[i] = ext_start[i+1];
              ext_len[i] = ext_len[i+1];
            end
            file_cnt--;
          end
        end
        default: res.status = ST_NOTFOUND;
      endcase
    end
    return res;
  endfunction

  task automatic add_request(logic [ACTION_BITS-1:0] action, logic [NAME_BITS-1:0] name,
                             logic [ADDRESS_BITS-1:0] len);
    request_t r;
    r.action = action;
    r.name = name;
    r.len = len;
    pending_reqs.push_back(r);
    queued_cnt++;
  endtask

  // Mostly well-formed traffic on a shared name pool so that finds and erases hit;
  // a few zero names, fresh names and undefined actions as noise.
  task automatic add_random_requests(int count, logic [ADDRESS_BITS-1:0] lim);
    int n, roll, span;
    logic [ACTION_BITS-1:0]  action;
    logic [NAME_BITS-1:0]    name;
    logic [ADDRESS_BITS-1:0] len;
    span = int'(lim) / 6 + 1;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) name = '0;
      else if (roll < 6) name = {$urandom, $urandom};
      else name = name_pool[$urandom_range(0, NAME_POOL - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 40) action = ACT_STORE;
      else if (roll < 65) action = ACT_FIND;
      else if (roll < 97) action = ACT_ERASE;
      else action = ACT_UNDEFINED;
      roll = $urandom_range(0, 99);
      if (roll < 25) len = '0;
      else if (roll < 70) len = ADDRESS_BITS'($urandom_range(0, span));
      else if (roll < 90) len = ADDRESS_BITS'($urandom_range(0, 1023));
      else len = ADDRESS_BITS'(1023 - $urandom_range(0, 15));
      add_request(action, name, len);
    end
  endtask

  // Hold until every queued item has gone in and every result has come back.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || accepted_cnt != queued_cnt ||
           expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Sender: present the next pending item once the current one is taken,
  // with random idle gaps except in the steady final phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (!steady_traffic && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 3);
        req_ch.valid <= 1'b0;
      end else begin
        drive_req = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.action <= drive_req.action;
        req_ch.file_name <= drive_req.name;
        req_ch.file_length <= drive_req.len;
      end
    end
  end

  // Predict at the handshake, from the values the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready) begin
      seen_req.action = req_ch.action;
      seen_req.name = req_ch.file_name;
      seen_req.len = req_ch.file_length;
      expected_results.push_back(predict_request(seen_req));
      accepted_cnt++;
    end
  end

  // Receiver: stall in random bursts, except in the steady final phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (steady_traffic) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 3);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Compare each returned item with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: status %0d start %0d length %0d",
                 $time, res_ch.status, res_ch.start_address, res_ch.extent_length);
      end else begin
        due_result = expected_results.pop_front();
        if (res_ch.status !== due_result.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d",
                   $time, due_result.status, res_ch.status);
        end
        if (res_ch.start_address !== due_result.start) begin
          mismatches++;
          $display("%0t: start_address expected %0d actual %0d",
                   $time, due_result.start, res_ch.start_address);
        end
        if (res_ch.extent_length !== due_result.len) begin
          mismatches++;
          $display("%0t: extent_length expected %0d actual %0d",
                   $time, due_result.len, res_ch.extent_length);
        end
      end
    end
  end

  // Main sequence: reset, directed items at the reset space_end, then random
  // phases, each opened by a space_end write on an idle block.
  initial begin
    logic [ADDRESS_BITS-1:0] phase_limits [6];
    int p, k;
    phase_limits = '{10'd1023, 10'd0, 10'd1, 10'd200, 10'd640, 10'd999};
    for (k = 0; k < NAME_POOL; k++) begin
      name_pool[k] = {$urandom, $urandom};
      if (name_pool[k] == '0) name_pool[k] = NAME_BITS'(1);
    end

    // Zero names, misses and the undefined action.
    add_request(ACT_STORE, '0, 10'd5);
    add_request(ACT_FIND, '0, '0);
    add_request(ACT_FIND, name_pool[0], '0);
    add_request(ACT_ERASE, name_pool[0], '0);
    add_request(ACT_UNDEFINED, name_pool[0], '0);
    // Zero length lands at address 0; an exact fit of the whole space is taken.
    add_request(ACT_STORE, name_pool[0], 10'd0);
    add_request(ACT_STORE, name_pool[1], 10'd1023);
    add_request(ACT_STORE, name_pool[1], 10'd999);
    add_request(ACT_STORE, name_pool[0], 10'd3);
    add_request(ACT_FIND, name_pool[0], '0);
    add_request(ACT_ERASE, name_pool[0], '0);
    add_request(ACT_STORE, name_pool[2], 10'd0);
    add_request(ACT_STORE, name_pool[3], 10'd1);
    // Fill the table with zero-length extents, then hit the full check.
    for (k = 4; k < 18; k++)
      add_request(ACT_STORE, name_pool[k], 10'd0);
    add_request(ACT_STORE, name_pool[18], 10'd0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < 6; p++) begin
      wait_drained();
      cfg_we <= 1'b1;
      cfg_wdata <= phase_limits[p];
      space_limit = phase_limits[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      if (p == 5) steady_traffic = 1'b1;
      add_random_requests(PHASE_ITEMS, phase_limits[p]);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ first_fit_extent_file_table.f @@
+incdir+src
src/ffeft_pkg.sv
src/ffeft_if.sv
src/ffeft_dp.sv
src/ffeft_ctrl.sv
src/first_fit_extent_file_table.sv
sim/tb_first_fit_extent_file_table.sv
